>>> rtl/rsem_pkg.sv
package rsem_pkg;

  // default sizes
  localparam int DATA_WIDTH_DEF  = 32;
  localparam int REG_COUNT_DEF   = 64;
  localparam int STACK_DEPTH_DEF = 32;

  // fixed field widths
  localparam int REQ_W   = 3;
  localparam int IDX_W   = 6;
  localparam int OP_W    = 3;
  localparam int IMM_W   = 32;
  localparam int SLOT_W  = 5;
  localparam int KIND_W  = 2;
  localparam int VAL_W   = 32;
  localparam int WRAP_W  = 5;

  localparam logic [WRAP_W-1:0] WRAP_LIMIT_RST = 5'd20;

  // request codes
  localparam logic [REQ_W-1:0] REQ_LOAD_IMM = 3'd0;
  localparam logic [REQ_W-1:0] REQ_COMPUTE  = 3'd1;
  localparam logic [REQ_W-1:0] REQ_LOAD_STK = 3'd2;
  localparam logic [REQ_W-1:0] REQ_PUSH     = 3'd3;
  localparam logic [REQ_W-1:0] REQ_PRINT    = 3'd4;

  // alu operation codes
  localparam logic [OP_W-1:0] ALU_ADD = 3'd0;
  localparam logic [OP_W-1:0] ALU_SUB = 3'd1;
  localparam logic [OP_W-1:0] ALU_MUL = 3'd2;
  localparam logic [OP_W-1:0] ALU_DIV = 3'd3;
  localparam logic [OP_W-1:0] ALU_REM = 3'd4;

  // result kinds
  localparam logic [KIND_W-1:0] KIND_NONE  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PRINT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PUSH  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DIV0  = 2'd3;

  // control bundle toward the serial alu
  typedef struct packed {
    logic            start;
    logic [OP_W-1:0] op;
  } alu_req_t;

  // narrow index reduced modulo m by binary compare and subtract
  function automatic logic [IDX_W-1:0] reduce_idx(logic [IDX_W-1:0] v, int m);
    int r;
    r = int'(v);
    for (int k = IDX_W - 1; k >= 0; k--) begin
      if (r >= (m << k)) begin
        r = r - (m << k);
      end
    end
    return IDX_W'(r);
  endfunction

endpackage

>>> rtl/rsem_ram.sv
module rsem_ram #(
  parameter int Width = 32,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/rsem_alu.sv
module rsem_alu import rsem_pkg::*; #(
  parameter int DataWidth = DATA_WIDTH_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  alu_req_t             alu_req_i,
  input  logic [DataWidth-1:0] a_i,
  input  logic [DataWidth-1:0] b_i,
  output logic                 done_o,
  output logic [DataWidth-1:0] result_o
);

  localparam int CntW = $clog2(DataWidth + 1);
  localparam logic [CntW-1:0] LastCnt = CntW'(DataWidth - 1);

  logic            run_q, fix_q, done_q;
  logic [CntW-1:0] cnt_q;
  logic [OP_W-1:0] op_q;
  logic [DataWidth-1:0] x_q, y_q, acc_q, res_q;
  logic            carry_q, neg_q;

  logic                 na, nb;
  logic [DataWidth-1:0] ma, mb;
  logic [DataWidth-1:0] rshift, mul_sum, fix_val;
  logic [DataWidth:0]   diff;
  logic                 sum_bit, carry_n;

  // operand magnitudes for divide and remainder
  assign na = a_i[DataWidth-1];
  assign nb = b_i[DataWidth-1];
  assign ma = na ? (~a_i + 1'b1) : a_i;
  assign mb = nb ? (~b_i + 1'b1) : b_i;

  // one step of each serial algorithm
  assign sum_bit = x_q[0] ^ y_q[0] ^ carry_q;
  assign carry_n = (x_q[0] & y_q[0]) | (carry_q & (x_q[0] ^ y_q[0]));
  assign mul_sum = acc_q + (y_q[0] ? x_q : '0);
  assign rshift  = {acc_q[DataWidth-2:0], x_q[DataWidth-1]};
  assign diff    = {1'b0, rshift} - {1'b0, y_q};
  assign fix_val = (op_q == ALU_DIV) ? x_q : acc_q;

  // sequencing control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      fix_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= fix_q;
      fix_q  <= 1'b0;
      if (alu_req_i.start) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LastCnt) begin
          run_q <= 1'b0;
          fix_q <= 1'b1;
        end
      end
    end
  end

  // datapath: one bit per cycle through the operand shift registers
  always_ff @(posedge clk_i) begin
    if (alu_req_i.start) begin
      op_q    <= alu_req_i.op;
      acc_q   <= '0;
      carry_q <= (alu_req_i.op == ALU_SUB);
      neg_q   <= 1'b0;
      x_q     <= a_i;
      y_q     <= b_i;
      case (alu_req_i.op)
        ALU_SUB: y_q <= ~b_i;
        ALU_DIV: begin
          x_q   <= ma;
          y_q   <= mb;
          neg_q <= na ^ nb;
        end
        ALU_REM: begin
          x_q   <= ma;
          y_q   <= mb;
          neg_q <= na;
        end
        default: ;
      endcase
    end else if (run_q) begin
      case (op_q)
        ALU_ADD, ALU_SUB: begin
          acc_q   <= {sum_bit, acc_q[DataWidth-1:1]};
          x_q     <= x_q >> 1;
          y_q     <= y_q >> 1;
          carry_q <= carry_n;
        end
        ALU_MUL: begin
          acc_q <= mul_sum;
          x_q   <= x_q << 1;
          y_q   <= y_q >> 1;
        end
        ALU_DIV, ALU_REM: begin
          if (!diff[DataWidth]) begin
            acc_q <= diff[DataWidth-1:0];
            x_q   <= {x_q[DataWidth-2:0], 1'b1};
          end else begin
            acc_q <= rshift;
            x_q   <= {x_q[DataWidth-2:0], 1'b0};
          end
        end
        default: ;
      endcase
    end
    // sign fix of the quotient or remainder
    if (fix_q) begin
      res_q <= neg_q ? (~fix_val + 1'b1) : fix_val;
    end
  end

  assign done_o   = done_q;
  assign result_o = res_q;

endmodule

>>> rtl/register_stack_expression_machine_top.sv
// Register/stack expression machine: one instruction per start pulse, taken
// when start is high and busy is low; each instruction gives exactly one
// result, shown on the out ports for a single cycle with out_valid_o high,
// and the receiver must take it then since nothing can hold it. Load
// immediate and an unknown request or alu operation finish in the decode
// state; load from stack, push and print pass through a memory read state; a
// divide or remainder by zero ends after both operand reads; any other compute
// waits on the bit-serial alu, which works bit by bit through the operands on
// add, subtract, multiply, divide and remainder. busy falls in the cycle of the
// strobe. Register file and stack are block memories with one read port each
// and are not cleared: read only what was written.
module register_stack_expression_machine_top import rsem_pkg::*; #(
  parameter int RegCount   = REG_COUNT_DEF,
  parameter int StackDepth = STACK_DEPTH_DEF,
  parameter int DataWidth  = DATA_WIDTH_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  output logic              busy,
  input  logic              cfg_we_i,
  input  logic [WRAP_W-1:0] cfg_wdata_i,
  input  logic [REQ_W-1:0]  req_type_i,
  input  logic [IDX_W-1:0]  dest_reg_i,
  input  logic [IDX_W-1:0]  src_a_i,
  input  logic [IDX_W-1:0]  src_b_i,
  input  logic [OP_W-1:0]   alu_op_i,
  input  logic signed [IMM_W-1:0] immediate_i,
  input  logic [SLOT_W-1:0] stack_slot_i,
  output logic              out_valid_o,
  output logic [KIND_W-1:0] out_kind_o,
  output logic signed [VAL_W-1:0] out_value_o,
  output logic [SLOT_W-1:0] out_slot_o
);

  localparam int RiW = $clog2(RegCount);
  localparam int SpW = $clog2(StackDepth);
  localparam int CmpW = (SpW > WRAP_W) ? SpW : WRAP_W;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_RA   = 3'd2;
  localparam logic [2:0] S_RB   = 3'd3;
  localparam logic [2:0] S_ALU  = 3'd4;
  localparam logic [2:0] S_SK   = 3'd5;
  localparam logic [2:0] S_PA   = 3'd6;
  localparam logic [2:0] S_PR   = 3'd7;

  logic [2:0] state_q, state_d;
  logic [WRAP_W-1:0] wrap_q;
  logic [SpW-1:0] sp_q, sp_d, sp_eff;
  logic [SpW:0]   sp_inc;

  logic [REQ_W-1:0] req_q;
  logic [OP_W-1:0]  op_q;
  logic [IMM_W-1:0] imm_q;
  logic [RiW-1:0]   rd_q, ra_q, rb_q;
  logic [SpW-1:0]   slot_q;
  logic [DataWidth-1:0] a_q;

  logic              valid_q, valid_d;
  logic [KIND_W-1:0] kind_q, kind_d;
  logic [VAL_W-1:0]  value_q, value_d;
  logic [SLOT_W-1:0] oslot_q, oslot_d;

  logic                 rf_we, rf_re;
  logic [RiW-1:0]       rf_waddr, rf_raddr;
  logic [DataWidth-1:0] rf_wdata, rf_rdata;
  logic                 sk_we, sk_re;
  logic [DataWidth-1:0] sk_rdata;

  alu_req_t             alu_req;
  logic                 alu_done;
  logic [DataWidth-1:0] alu_result;
  logic                 accept, b_zero, is_divide;

  assign accept    = start && !busy;
  assign busy      = (state_q != S_IDLE);
  assign b_zero    = (rf_rdata == '0);
  assign is_divide = (op_q == ALU_DIV) || (op_q == ALU_REM);

  // stack pointer wrap before a push and increment after it
  assign sp_eff = (CmpW'(sp_q) > CmpW'(wrap_q)) ? '0 : sp_q;
  assign sp_inc = {1'b0, sp_eff} + 1'b1;

  rsem_ram #(.Width(DataWidth), .Depth(RegCount)) u_regfile (
    .clk_i   (clk_i),
    .we_i    (rf_we),
    .waddr_i (rf_waddr),
    .wdata_i (rf_wdata),
    .re_i    (rf_re),
    .raddr_i (rf_raddr),
    .rdata_o (rf_rdata)
  );

  rsem_ram #(.Width(DataWidth), .Depth(StackDepth)) u_stack (
    .clk_i   (clk_i),
    .we_i    (sk_we),
    .waddr_i (sp_eff),
    .wdata_i (rf_rdata),
    .re_i    (sk_re),
    .raddr_i (slot_q),
    .rdata_o (sk_rdata)
  );

  rsem_alu #(.DataWidth(DataWidth)) u_alu (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .alu_req_i (alu_req),
    .a_i       (a_q),
    .b_i       (rf_rdata),
    .done_o    (alu_done),
    .result_o  (alu_result)
  );

  // instruction sequencer
  always_comb begin
    state_d   = state_q;
    sp_d      = sp_q;
    valid_d   = 1'b0;
    kind_d    = kind_q;
    value_d   = value_q;
    oslot_d   = oslot_q;
    rf_we     = 1'b0;
    rf_waddr  = rd_q;
    rf_wdata  = DataWidth'($signed(imm_q));
    rf_re     = 1'b0;
    rf_raddr  = ra_q;
    sk_we     = 1'b0;
    sk_re     = 1'b0;
    alu_req.start = 1'b0;
    alu_req.op    = op_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        kind_d  = KIND_NONE;
        value_d = '0;
        oslot_d = '0;
        case (req_q)
          REQ_LOAD_IMM: begin
            rf_we   = 1'b1;
            valid_d = 1'b1;
            state_d = S_IDLE;
          end
          REQ_COMPUTE: begin
            if (op_q > ALU_REM) begin
              valid_d = 1'b1;
              state_d = S_IDLE;
            end else begin
              rf_re   = 1'b1;
              state_d = S_RA;
            end
          end
          REQ_LOAD_STK: begin
            sk_re   = 1'b1;
            state_d = S_SK;
          end
          REQ_PUSH: begin
            rf_re   = 1'b1;
            state_d = S_PA;
          end
          REQ_PRINT: begin
            rf_re    = 1'b1;
            rf_raddr = rd_q;
            state_d  = S_PR;
          end
          default: begin
            valid_d = 1'b1;
            state_d = S_IDLE;
          end
        endcase
      end
      S_RA: begin
        rf_re    = 1'b1;
        rf_raddr = rb_q;
        state_d  = S_RB;
      end
      S_RB: begin
        if (is_divide && b_zero) begin
          kind_d  = KIND_DIV0;
          valid_d = 1'b1;
          state_d = S_IDLE;
        end else begin
          alu_req.start = 1'b1;
          state_d       = S_ALU;
        end
      end
      S_ALU: begin
        if (alu_done) begin
          rf_we    = 1'b1;
          rf_wdata = alu_result;
          valid_d  = 1'b1;
          state_d  = S_IDLE;
        end
      end
      S_SK: begin
        rf_we    = 1'b1;
        rf_wdata = sk_rdata;
        valid_d  = 1'b1;
        state_d  = S_IDLE;
      end
      S_PA: begin
        sk_we   = 1'b1;
        kind_d  = KIND_PUSH;
        value_d = VAL_W'(rf_rdata);
        oslot_d = SLOT_W'(sp_eff);
        sp_d    = (sp_inc == (SpW + 1)'(StackDepth)) ? '0 : sp_inc[SpW-1:0];
        valid_d = 1'b1;
        state_d = S_IDLE;
      end
      S_PR: begin
        kind_d  = KIND_PRINT;
        value_d = VAL_W'(rf_rdata);
        valid_d = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      sp_q    <= '0;
      wrap_q  <= WRAP_LIMIT_RST;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      sp_q    <= sp_d;
      valid_q <= valid_d;
      if (cfg_we_i) begin
        wrap_q <= cfg_wdata_i;
      end
    end
  end

  // instruction fields, operand and result payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_q  <= req_type_i;
      op_q   <= alu_op_i;
      imm_q  <= immediate_i;
      rd_q   <= RiW'(reduce_idx(dest_reg_i, RegCount));
      ra_q   <= RiW'(reduce_idx(src_a_i, RegCount));
      rb_q   <= RiW'(reduce_idx(src_b_i, RegCount));
      slot_q <= SpW'(reduce_idx({1'b0, stack_slot_i}, StackDepth));
    end
    if (state_q == S_RA) begin
      a_q <= rf_rdata;
    end
    kind_q  <= kind_d;
    value_q <= value_d;
    oslot_q <= oslot_d;
  end

  assign out_valid_o = valid_q;
  assign out_kind_o  = kind_q;
  assign out_value_o = value_q;
  assign out_slot_o  = oslot_q;

endmodule
